// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the RTL that checks itself.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked at every rising edge of clk outside reset.
`define ASSERT_IMPLY(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

`endif

// File: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Screen geometry, character codes, result kinds and shared types of the
// text console character writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int TOTAL       = COLUMNS * ROWS;
  localparam int TAB_STOP    = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int POS_W   = 11;
  localparam int KIND_W  = 2;
  localparam int CLS_W   = 2;
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS + 1);
  localparam int CUR_W   = $clog2(TOTAL + 1);
  localparam int TAB_W   = $clog2(TAB_STOP + 1);
  localparam int TAB_LSB = $clog2(TAB_STOP);
  localparam int DATA_W  = 40;

  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h02;

  localparam logic [CLS_W-1:0] CLS_GLYPH   = 2'd0;
  localparam logic [CLS_W-1:0] CLS_NEWLINE = 2'd1;
  localparam logic [CLS_W-1:0] CLS_TAB     = 2'd2;
  localparam logic [CLS_W-1:0] CLS_BACK    = 2'd3;

  localparam logic [KIND_W-1:0] KIND_CELL   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ROW    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MARK   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd3;

  typedef struct packed {
    logic [CLS_W-1:0]  cls;
    logic [CHAR_W-1:0] ch;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  position;
    logic [CHAR_W-1:0] glyph;
    logic [ATTR_W-1:0] attribute;
    logic [POS_W-1:0]  cursor;
    logic              last;
  } result_t;

  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

endpackage

`default_nettype wire

// File: rtl/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// Accepts character transactions and sorts each byte into glyph, newline,
// tab or backspace before it enters the work queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_front (
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [tcw_pkg::CHAR_W-1:0]  s_tdata,
  input  wire tcw_pkg::queue_status_t      q_status,
  output logic                             push,
  output tcw_pkg::item_t                   push_item
);

  logic [tcw_pkg::CLS_W-1:0] cls;

  always_comb begin
    priority if (s_tdata == tcw_pkg::CH_LF || s_tdata == tcw_pkg::CH_CR) begin
      cls = tcw_pkg::CLS_NEWLINE;
    end else if (s_tdata == tcw_pkg::CH_TAB) begin
      cls = tcw_pkg::CLS_TAB;
    end else if (s_tdata == tcw_pkg::CH_BS) begin
      cls = tcw_pkg::CLS_BACK;
    end else begin
      cls = tcw_pkg::CLS_GLYPH;
    end
  end

  assign s_tready       = !q_status.full;
  assign push           = s_tvalid && !q_status.full;
  assign push_item.cls  = cls;
  assign push_item.ch   = s_tdata;

endmodule

`default_nettype wire

// File: rtl/tcw_queue.sv
// ----------------------------------------------------------------------------
// tcw_queue
// Short first-in first-out queue of classified characters between the
// front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire tcw_pkg::item_t   push_item,
  input  wire logic             pop,
  output tcw_pkg::item_t        pop_item,
  output tcw_pkg::queue_status_t status
);

  localparam int PTR_W = $clog2(tcw_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(tcw_pkg::QUEUE_DEPTH + 1);

  tcw_pkg::item_t   mem [tcw_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (count == CNT_W'(tcw_pkg::QUEUE_DEPTH));
  assign status.valid = (count != '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && status.valid;
  assign pop_item     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back
// Sequencer that carries out one queued character: wrap handling, old-log
// row clears, the cell writes and the cursor report, one result per cycle
// into an output register whenever that register is free to take it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire tcw_pkg::queue_status_t      q_status,
  input  wire tcw_pkg::item_t              q_item,
  output logic                             pop,
  input  wire logic [tcw_pkg::ATTR_W-1:0]  attr,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output tcw_pkg::result_t                 out_data
);

  localparam int COL_W = tcw_pkg::COL_W;
  localparam int ROW_W = tcw_pkg::ROW_W;
  localparam int CUR_W = tcw_pkg::CUR_W;
  localparam int TAB_W = tcw_pkg::TAB_W;
  localparam int POS_W = tcw_pkg::POS_W;
  localparam int TAB_LSB_IDX = tcw_pkg::TAB_LSB - 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ROWS   = 3'd1;
  localparam logic [2:0] ST_ACT    = 3'd2;
  localparam logic [2:0] ST_TAB    = 3'd3;
  localparam logic [2:0] ST_REPORT = 3'd4;

  logic [2:0]       state, state_next;
  logic [CUR_W-1:0] cursor, cursor_next;
  logic [COL_W-1:0] col, col_next;
  logic [ROW_W-1:0] row, row_next;
  logic             wrapped, wrapped_next;
  tcw_pkg::item_t   item, item_next;
  logic [1:0]       hdr_idx, hdr_idx_next;
  logic [TAB_W-1:0] tab_cnt, tab_cnt_next;

  logic             out_free;
  logic             emit;
  tcw_pkg::result_t res;
  logic             wrap_now;
  logic             at_end;
  logic [ROW_W:0]   row_sum;
  logic [CUR_W-1:0] cursor_inc;
  logic [COL_W-1:0] col_inc;
  logic [ROW_W-1:0] row_inc;

  assign out_free = !out_valid || out_ready;
  assign at_end   = (row == ROW_W'(tcw_pkg::ROWS));
  assign wrap_now = at_end;
  assign row_sum  = {1'b0, row} + (ROW_W + 1)'(hdr_idx);

  always_comb begin
    cursor_inc = cursor + 1'b1;
    if (col == COL_W'(tcw_pkg::COLUMNS - 1)) begin
      col_inc = '0;
      row_inc = row + 1'b1;
    end else begin
      col_inc = col + 1'b1;
      row_inc = row;
    end
  end

  always_comb begin
    state_next    = state;
    cursor_next   = cursor;
    col_next      = col;
    row_next      = row;
    wrapped_next  = wrapped;
    item_next     = item;
    hdr_idx_next  = hdr_idx;
    tab_cnt_next  = tab_cnt;
    pop           = 1'b0;
    emit          = 1'b0;
    res.kind      = tcw_pkg::KIND_CELL;
    res.position  = POS_W'(cursor);
    res.glyph     = tcw_pkg::CH_BLANK;
    res.attribute = attr;
    res.cursor    = '0;
    res.last      = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (q_status.valid) begin
          pop       = 1'b1;
          item_next = q_item;
          if (wrap_now) begin
            cursor_next  = '0;
            col_next     = '0;
            row_next     = '0;
            wrapped_next = 1'b1;
          end
          hdr_idx_next = '0;
          if ((wrapped || wrap_now) && (wrap_now || col == '0)) begin
            state_next = ST_ROWS;
          end else begin
            state_next = ST_ACT;
          end
        end
      end
      ST_ROWS: begin
        if (out_free) begin
          if (row_sum < (ROW_W + 1)'(tcw_pkg::ROWS)) begin
            emit         = 1'b1;
            res.kind     = (hdr_idx == 2'd2) ? tcw_pkg::KIND_MARK : tcw_pkg::KIND_ROW;
            res.position = POS_W'(row_sum);
          end
          hdr_idx_next = hdr_idx + 1'b1;
          if (hdr_idx == 2'd2) begin
            state_next = ST_ACT;
          end
        end
      end
      ST_ACT: begin
        if (out_free) begin
          state_next = ST_REPORT;
          unique case (item.cls)
            tcw_pkg::CLS_NEWLINE: begin
              if (row < ROW_W'(tcw_pkg::ROWS - 1)) begin
                cursor_next = cursor + CUR_W'(tcw_pkg::COLUMNS) - CUR_W'(col);
                col_next    = '0;
                row_next    = row + 1'b1;
              end else begin
                cursor_next  = '0;
                col_next     = '0;
                row_next     = '0;
                wrapped_next = 1'b1;
              end
            end
            tcw_pkg::CLS_BACK: begin
              if (cursor != '0) begin
                emit         = 1'b1;
                res.position = POS_W'(cursor - 1'b1);
                cursor_next  = cursor - 1'b1;
                if (col == '0) begin
                  col_next = COL_W'(tcw_pkg::COLUMNS - 1);
                  row_next = row - 1'b1;
                end else begin
                  col_next = col - 1'b1;
                end
              end
            end
            tcw_pkg::CLS_TAB: begin
              tab_cnt_next = TAB_W'(tcw_pkg::TAB_STOP) - TAB_W'(col[TAB_LSB_IDX:0]);
              state_next   = ST_TAB;
            end
            tcw_pkg::CLS_GLYPH: begin
              emit        = 1'b1;
              res.glyph   = item.ch;
              cursor_next = cursor_inc;
              col_next    = col_inc;
              row_next    = row_inc;
            end
            default: begin
              state_next = ST_REPORT;
            end
          endcase
        end
      end
      ST_TAB: begin
        if (out_free) begin
          if (!at_end) begin
            emit         = 1'b1;
            cursor_next  = cursor_inc;
            col_next     = col_inc;
            row_next     = row_inc;
            tab_cnt_next = tab_cnt - 1'b1;
            if (tab_cnt == TAB_W'(1)) begin
              state_next = ST_REPORT;
            end
          end else begin
            cursor_next  = '0;
            col_next     = '0;
            row_next     = '0;
            wrapped_next = 1'b1;
            state_next   = ST_REPORT;
          end
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          emit          = 1'b1;
          res.kind      = tcw_pkg::KIND_REPORT;
          res.position  = '0;
          res.attribute = '0;
          res.cursor    = POS_W'(cursor);
          res.last      = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cursor  <= '0;
      col     <= '0;
      row     <= '0;
      wrapped <= 1'b0;
      hdr_idx <= '0;
      tab_cnt <= '0;
    end else begin
      state   <= state_next;
      cursor  <= cursor_next;
      col     <= col_next;
      row     <= row_next;
      wrapped <= wrapped_next;
      hdr_idx <= hdr_idx_next;
      tab_cnt <= tab_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    item <= item_next;
    if (emit) begin
      out_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/text_console_char_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_char_writer_unit
// Text console character writer: one character in, a run of screen cell and
// row operations out, ended by a cursor report.
//
//   channel | direction | tdata / data                  | tuser | tlast
//   s_      | in        | character                     | -     | -
//   m_      | out       | position, glyph, attr, cursor | kind  | last
//   cfg_    | in        | cell_attribute                | -     | -
//
// In the back sequencer a character is loaded, then come the old-log row
// clears at a row start after a wrap, the action, the blanks of a tab (up
// to eight) and the cursor report.
// Results leave one per cycle through an output register; a stalled m_ side
// holds the sequencer while the four-entry queue keeps taking characters.
// Reset clears the cursor, the wrapped flag and the queue, and loads the
// attribute with 0x02.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module text_console_char_writer_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [7:0]                  s_tdata,   // [7:0] character
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [tcw_pkg::DATA_W-1:0]       m_tdata,   // [10:0] position, [18:11] glyph,
                                                      // [26:19] attribute, [37:27] cursor
  output logic [tcw_pkg::KIND_W-1:0]       m_tuser,   // [1:0] kind
  output logic                             m_tlast,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [tcw_pkg::ATTR_W-1:0]  cfg_data
);

  logic [tcw_pkg::ATTR_W-1:0] cell_attribute;
  tcw_pkg::queue_status_t     q_status;
  tcw_pkg::item_t             push_item;
  tcw_pkg::item_t             pop_item;
  tcw_pkg::result_t           result;
  logic                       push;
  logic                       pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_attribute <= tcw_pkg::ATTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cell_attribute <= cfg_data;
    end
  end

  tcw_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  tcw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  tcw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .q_item    (pop_item),
    .pop       (pop),
    .attr      (cell_attribute),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (result)
  );

  assign m_tdata = {2'b00, result.cursor, result.attribute, result.glyph, result.position};
  assign m_tuser = result.kind;
  assign m_tlast = result.last;

`include "assert_macros.svh"

  `ASSERT_CLK(a_last_on_report, !m_tvalid || (m_tlast == (m_tuser == tcw_pkg::KIND_REPORT)), "last not on cursor report")
  `ASSERT_IMPLY(a_row_in_screen, m_tvalid && (m_tuser == tcw_pkg::KIND_ROW || m_tuser == tcw_pkg::KIND_MARK), result.position < tcw_pkg::POS_W'(tcw_pkg::ROWS), "row operation past screen bottom")
  `ASSERT_IMPLY(a_report_fields, m_tvalid && m_tlast, result.attribute == '0 && result.glyph == tcw_pkg::CH_BLANK && result.position == '0, "cursor report fields not cleared")

endmodule

`default_nettype wire
